// ===== hw/rtl/btam_pkg.sv =====
// ----------------------------------------------------------------------------
// btam_pkg
// Shared types, constants and helpers of the tile address mapper.
// ----------------------------------------------------------------------------
package btam_pkg;

  localparam int MaxDim  = 4096;
  localparam int MaxGrid = 64;
  localparam int MaxBpp  = 4;

  localparam int DimW   = 13;
  localparam int GridW  = 7;
  localparam int BppW   = 3;
  localparam int BytesW = 15;
  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 3;

  localparam int QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgImageWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBytesPerPix  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGridRows     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGridCols     = 3'd4;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusOutside = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  typedef struct packed {
    logic              ok;
    logic [GridW-1:0]  rows;
    logic [GridW-1:0]  cols;
    logic [DimW-1:0]   base_w;
    logic [DimW-1:0]   base_h;
    logic [DimW-1:0]   last_w;
    logic [DimW-1:0]   last_h;
    logic [BytesW-1:0] base_wb;
    logic [BytesW-1:0] last_wb;
    logic [BytesW-1:0] base_rb;
    logic [BytesW-1:0] last_rb;
    logic [BytesW-1:0] stride;
  } geom_t;

  typedef struct packed {
    logic              ok;
    logic              outside;
    logic              pad;
    logic [13:0]       row_idx;
    logic [BytesW-1:0] col_off;
    logic [13:0]       out_byte;
    logic [DimW-1:0]   tile_w;
    logic [DimW-1:0]   tile_h;
    logic [BytesW-1:0] row_bytes;
    logic [DimW-1:0]   tile_num;
  } entry_t;

  function automatic logic [BytesW-1:0] pad_row(input logic [15:0] bytes);
    logic [15:0] sum;
    sum = bytes + 16'd3;
    return {sum[BytesW-1:2], 2'b00};
  endfunction

endpackage

// ===== hw/rtl/btam_cfg.sv =====
// ----------------------------------------------------------------------------
// btam_cfg
// Configuration registers and derived tile geometry, worked out after each
// write by a shared restoring divider.
// ----------------------------------------------------------------------------
module btam_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [btam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [btam_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          geom_ready_o,
  output btam_pkg::geom_t               geom_o
);
  import btam_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD_W = 3'd1;
  localparam logic [2:0] ST_DIV_W  = 3'd2;
  localparam logic [2:0] ST_LOAD_H = 3'd3;
  localparam logic [2:0] ST_DIV_H  = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;

  localparam logic [3:0] DivLast = 4'(DimW - 1);

  logic [2:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [DimW-1:0]  width_q, height_q;
  logic [BppW-1:0]  bpp_q;
  logic [GridW-1:0] rows_q, cols_q;

  logic [DimW-1:0]  dvd_q;
  logic [GridW-1:0] rem_q;
  logic [DimW-1:0]  base_w_q, base_h_q;
  logic [GridW-1:0] rem_w_q, rem_h_q;
  geom_t            geom_q;

  logic [GridW-1:0] div_sel;
  logic [GridW:0]   rem_sh;
  logic             take;
  logic [GridW-1:0] rem_nx;
  logic [DimW-1:0]  dvd_nx;
  logic [DimW-1:0]  last_w, last_h;
  logic [15:0]      base_wb, last_wb, img_b;
  logic             cfg_ok;

  always_comb begin
    div_sel = (state_q == ST_DIV_H) ? rows_q : cols_q;
    rem_sh  = {rem_q, dvd_q[DimW-1]};
    take    = rem_sh >= {1'b0, div_sel};
    rem_nx  = take ? GridW'(rem_sh - {1'b0, div_sel}) : rem_sh[GridW-1:0];
    dvd_nx  = {dvd_q[DimW-2:0], take};
  end

  always_comb begin
    last_w  = base_w_q + DimW'(rem_w_q);
    last_h  = base_h_q + DimW'(rem_h_q);
    base_wb = 16'(base_w_q) * 16'(bpp_q);
    last_wb = 16'(last_w) * 16'(bpp_q);
    img_b   = 16'(width_q) * 16'(bpp_q);
    cfg_ok  = (width_q >= DimW'(1)) && (width_q <= DimW'(MaxDim))
           && (height_q >= DimW'(1)) && (height_q <= DimW'(MaxDim))
           && (bpp_q >= BppW'(1)) && (bpp_q <= BppW'(MaxBpp))
           && (rows_q >= GridW'(1)) && (rows_q <= GridW'(MaxGrid))
           && (cols_q >= GridW'(1)) && (cols_q <= GridW'(MaxGrid))
           && (DimW'(rows_q) <= height_q) && (DimW'(cols_q) <= width_q);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_LOAD_W: begin
        state_d = ST_DIV_W;
        cnt_d   = '0;
      end
      ST_DIV_W: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DivLast) begin
          state_d = ST_LOAD_H;
        end
      end
      ST_LOAD_H: begin
        state_d = ST_DIV_H;
        cnt_d   = '0;
      end
      ST_DIV_H: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DivLast) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_LOAD_W;
      end
    endcase
    if (cfg_valid_i) begin
      state_d = ST_LOAD_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD_W;
      cnt_q    <= '0;
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      bpp_q    <= BppW'(3);
      rows_q   <= GridW'(1);
      cols_q   <= GridW'(1);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgImageWidth:  width_q  <= cfg_data_i[DimW-1:0];
          CfgImageHeight: height_q <= cfg_data_i[DimW-1:0];
          CfgBytesPerPix: bpp_q    <= cfg_data_i[BppW-1:0];
          CfgGridRows:    rows_q   <= cfg_data_i[GridW-1:0];
          CfgGridCols:    cols_q   <= cfg_data_i[GridW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD_W: begin
        dvd_q <= width_q;
        rem_q <= '0;
      end
      ST_LOAD_H: begin
        dvd_q <= height_q;
        rem_q <= '0;
      end
      ST_DIV_W: begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        if (cnt_q == DivLast) begin
          base_w_q <= dvd_nx;
          rem_w_q  <= rem_nx;
        end
      end
      ST_DIV_H: begin
        dvd_q <= dvd_nx;
        rem_q <= rem_nx;
        if (cnt_q == DivLast) begin
          base_h_q <= dvd_nx;
          rem_h_q  <= rem_nx;
        end
      end
      ST_MUL: begin
        geom_q.ok      <= cfg_ok;
        geom_q.rows    <= rows_q;
        geom_q.cols    <= cols_q;
        geom_q.base_w  <= base_w_q;
        geom_q.base_h  <= base_h_q;
        geom_q.last_w  <= last_w;
        geom_q.last_h  <= last_h;
        geom_q.base_wb <= base_wb[BytesW-1:0];
        geom_q.last_wb <= last_wb[BytesW-1:0];
        geom_q.base_rb <= pad_row(base_wb);
        geom_q.last_rb <= pad_row(last_wb);
        geom_q.stride  <= pad_row(img_b);
      end
      default: begin
      end
    endcase
  end

  assign geom_ready_o = (state_q == ST_IDLE);
  assign geom_o       = geom_q;

endmodule

// ===== hw/rtl/btam_front.sv =====
// ----------------------------------------------------------------------------
// btam_front
// Classifies a request: tile index check, tile geometry selection, position
// flags and the narrow row, column and tile number products.
// ----------------------------------------------------------------------------
module btam_front (
  input  logic                   push_i,
  input  logic [5:0]             tile_row_i,
  input  logic [5:0]             tile_col_i,
  input  logic [11:0]            out_row_i,
  input  logic [13:0]            out_byte_i,
  input  btam_pkg::geom_t        geom_i,
  output logic                   push_o,
  output btam_pkg::entry_t       entry_o
);
  import btam_pkg::*;

  logic [GridW-1:0]  tr, tc;
  logic              last_r, last_c;
  logic [DimW-1:0]   tw, th;
  logic [BytesW-1:0] db, rb;
  logic [18:0]       row_prod;
  logic [20:0]       col_prod;

  always_comb begin
    tr       = GridW'(tile_row_i);
    tc       = GridW'(tile_col_i);
    last_r   = tr == (geom_i.rows - GridW'(1));
    last_c   = tc == (geom_i.cols - GridW'(1));
    tw       = last_c ? geom_i.last_w : geom_i.base_w;
    th       = last_r ? geom_i.last_h : geom_i.base_h;
    db       = last_c ? geom_i.last_wb : geom_i.base_wb;
    rb       = last_c ? geom_i.last_rb : geom_i.base_rb;
    row_prod = 19'(tile_row_i) * 19'(geom_i.base_h);
    col_prod = 21'(tile_col_i) * 21'(geom_i.base_wb);

    entry_o.ok        = geom_i.ok && (tr < geom_i.rows) && (tc < geom_i.cols);
    entry_o.outside   = (DimW'(out_row_i) >= th) || (BytesW'(out_byte_i) >= rb);
    entry_o.pad       = BytesW'(out_byte_i) >= db;
    entry_o.row_idx   = {1'b0, row_prod[DimW-1:0]} + 14'(out_row_i);
    entry_o.col_off   = col_prod[BytesW-1:0];
    entry_o.out_byte  = out_byte_i;
    entry_o.tile_w    = tw;
    entry_o.tile_h    = th;
    entry_o.row_bytes = rb;
    entry_o.tile_num  = DimW'(tile_row_i) * DimW'(geom_i.cols)
                      + DimW'(tile_col_i) + DimW'(1);
  end

  assign push_o = push_i;

endmodule

// ===== hw/rtl/btam_fifo.sv =====
// ----------------------------------------------------------------------------
// btam_fifo
// Short queue of classified requests between the front and the back end.
// ----------------------------------------------------------------------------
module btam_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btam_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output btam_pkg::entry_t  entry_o
);
  import btam_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_q];

endmodule

// ===== hw/rtl/btam_back.sv =====
// ----------------------------------------------------------------------------
// btam_back
// Two-stage back end: source row and tile area products, then the final
// offset sum, status and result register.
// ----------------------------------------------------------------------------
module btam_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  btam_pkg::entry_t              entry_i,
  input  logic [btam_pkg::BytesW-1:0]   stride_i,
  output logic                          res_valid_o,
  output logic                          is_pad_o,
  output logic [25:0]                   src_offset_o,
  output logic [btam_pkg::DimW-1:0]     tile_width_o,
  output logic [btam_pkg::DimW-1:0]     tile_height_o,
  output logic [btam_pkg::BytesW-1:0]   tile_row_bytes_o,
  output logic [24:0]                   tile_pixels_o,
  output logic [btam_pkg::DimW-1:0]     tile_number_o,
  output logic [1:0]                    status_o
);
  import btam_pkg::*;

  logic        s1_valid_q, s2_valid_q;
  entry_t      s1_q;
  logic [25:0] s1_src_row_q;
  logic [24:0] s1_pix_q;

  logic        s2_pad_q;
  logic [25:0] s2_src_q;
  logic [DimW-1:0]   s2_tw_q, s2_th_q, s2_num_q;
  logic [BytesW-1:0] s2_rb_q;
  logic [24:0] s2_pix_q;
  logic [1:0]  s2_status_q;

  logic        hit;
  logic [25:0] src_sum;
  logic [1:0]  status_d;

  always_comb begin
    hit     = s1_q.ok && !s1_q.outside && !s1_q.pad;
    src_sum = s1_src_row_q + 26'(s1_q.col_off) + 26'(s1_q.out_byte);
    if (!s1_q.ok) begin
      status_d = StatusInvalid;
    end else if (s1_q.outside) begin
      status_d = StatusOutside;
    end else begin
      status_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_q         <= entry_i;
      s1_src_row_q <= 26'(entry_i.row_idx) * 26'(stride_i);
      s1_pix_q     <= 25'(entry_i.tile_w) * 25'(entry_i.tile_h);
    end
    if (s1_valid_q) begin
      s2_pad_q    <= s1_q.ok && !s1_q.outside && s1_q.pad;
      s2_src_q    <= hit ? src_sum : '0;
      s2_tw_q     <= s1_q.ok ? s1_q.tile_w : '0;
      s2_th_q     <= s1_q.ok ? s1_q.tile_h : '0;
      s2_rb_q     <= s1_q.ok ? s1_q.row_bytes : '0;
      s2_pix_q    <= s1_q.ok ? s1_pix_q : '0;
      s2_num_q    <= s1_q.ok ? s1_q.tile_num : '0;
      s2_status_q <= status_d;
    end
  end

  assign res_valid_o      = s2_valid_q;
  assign is_pad_o         = s2_pad_q;
  assign src_offset_o     = s2_src_q;
  assign tile_width_o     = s2_tw_q;
  assign tile_height_o    = s2_th_q;
  assign tile_row_bytes_o = s2_rb_q;
  assign tile_pixels_o    = s2_pix_q;
  assign tile_number_o    = s2_num_q;
  assign status_o         = s2_status_q;

endmodule

// ===== hw/rtl/bmp_tile_address_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// bmp_tile_address_mapper_unit
// Maps a byte position of a tile to its byte in the padded source raster.
// ----------------------------------------------------------------------------
// One request is taken per clock while busy is low; each result passes the
// queue and the registered back end, then appears on the result ports for
// one cycle with res_valid_o high, in request order, and the receiver cannot
// stall it. After reset and after every configuration write the block holds
// busy high while a shared serial divider (one quotient bit per cycle, 13
// bits for the width split, then 13 for the height split, after a load step
// for each, then a final product step) derives the tile geometry.
// ----------------------------------------------------------------------------
module bmp_tile_address_mapper_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [5:0]                    tile_row_i,
  input  logic [5:0]                    tile_col_i,
  input  logic [11:0]                   out_row_i,
  input  logic [13:0]                   out_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [btam_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [btam_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          res_valid_o,
  output logic                          is_pad_o,
  output logic [25:0]                   src_offset_o,
  output logic [12:0]                   tile_width_o,
  output logic [12:0]                   tile_height_o,
  output logic [14:0]                   tile_row_bytes_o,
  output logic [24:0]                   tile_pixels_o,
  output logic [12:0]                   tile_number_o,
  output logic [1:0]                    status_o
);
  import btam_pkg::*;

  geom_t  geom;
  logic   geom_ready;
  logic   accept, push;
  entry_t front_entry, head_entry;
  logic   q_full, q_empty;

  assign cfg_ready_o = 1'b1;
  assign busy        = !geom_ready || q_full;
  assign accept      = start && !busy;

  btam_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .geom_ready_o (geom_ready),
    .geom_o       (geom)
  );

  btam_front u_front (
    .push_i     (accept),
    .tile_row_i (tile_row_i),
    .tile_col_i (tile_col_i),
    .out_row_i  (out_row_i),
    .out_byte_i (out_byte_i),
    .geom_i     (geom),
    .push_o     (push),
    .entry_o    (front_entry)
  );

  btam_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (!q_empty),
    .full_o  (q_full),
    .empty_o (q_empty),
    .entry_o (head_entry)
  );

  btam_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (!q_empty),
    .entry_i          (head_entry),
    .stride_i         (geom.stride),
    .res_valid_o      (res_valid_o),
    .is_pad_o         (is_pad_o),
    .src_offset_o     (src_offset_o),
    .tile_width_o     (tile_width_o),
    .tile_height_o    (tile_height_o),
    .tile_row_bytes_o (tile_row_bytes_o),
    .tile_pixels_o    (tile_pixels_o),
    .tile_number_o    (tile_number_o),
    .status_o         (status_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile address mapper: a clocked driver feeds
// byte-position requests from a queue, a clocked monitor compares every
// result strobe field by field with a predicted tile mapping. Directed
// extremes, remainder tiles and invalid setups come first, then random
// grids with mostly in-tile positions under varying sender idling.
// ----------------------------------------------------------------------------
module tb_top;
  import btam_pkg::*;

  typedef struct {
    logic [5:0]  trow;
    logic [5:0]  tcol;
    logic [11:0] orow;
    logic [13:0] obyte;
  } tile_req_t;

  typedef struct packed {
    logic        is_pad;
    logic [25:0] src_offset;
    logic [12:0] tile_width;
    logic [12:0] tile_height;
    logic [14:0] tile_row_bytes;
    logic [24:0] tile_pixels;
    logic [12:0] tile_number;
    logic [1:0]  status;
  } tile_map_t;

  localparam int QuietLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [5:0]          tile_row_i = '0;
  logic [5:0]          tile_col_i = '0;
  logic [11:0]         out_row_i = '0;
  logic [13:0]         out_byte_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                res_valid_o;
  logic                is_pad_o;
  logic [25:0]         src_offset_o;
  logic [12:0]         tile_width_o;
  logic [12:0]         tile_height_o;
  logic [14:0]         tile_row_bytes_o;
  logic [24:0]         tile_pixels_o;
  logic [12:0]         tile_number_o;
  logic [1:0]          status_o;

  logic [12:0] img_w = 13'd1;
  logic [12:0] img_h = 13'd1;
  logic [2:0]  pix_bytes = 3'd3;
  logic [6:0]  grid_r = 7'd1;
  logic [6:0]  grid_c = 7'd1;

  tile_req_t tile_reqs[$];
  tile_map_t expected_maps[$];
  tile_map_t map_head;
  int        idle_pct = 0;
  int        mismatches = 0;
  int        quiet = 0;
  int        pct_list[3] = '{0, 80, 36};

  bmp_tile_address_mapper_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .tile_row_i      (tile_row_i),
    .tile_col_i      (tile_col_i),
    .out_row_i       (out_row_i),
    .out_byte_i      (out_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .res_valid_o     (res_valid_o),
    .is_pad_o        (is_pad_o),
    .src_offset_o    (src_offset_o),
    .tile_width_o    (tile_width_o),
    .tile_height_o   (tile_height_o),
    .tile_row_bytes_o(tile_row_bytes_o),
    .tile_pixels_o   (tile_pixels_o),
    .tile_number_o   (tile_number_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic setup_valid();
    return img_w >= 1 && img_w <= MaxDim && img_h >= 1 && img_h <= MaxDim &&
           pix_bytes >= 1 && pix_bytes <= MaxBpp &&
           grid_r >= 1 && grid_r <= MaxGrid && grid_c >= 1 && grid_c <= MaxGrid &&
           grid_r <= img_h && grid_c <= img_w;
  endfunction

  function automatic void tile_dims(input logic [5:0] trow, input logic [5:0] tcol,
                                    output longint unsigned tw, output longint unsigned th,
                                    output longint unsigned data, output longint unsigned rb);
    longint unsigned w, h, b, r, c, bw, bh;
    w = img_w;
    h = img_h;
    b = pix_bytes;
    r = grid_r;
    c = grid_c;
    bw = w / c;
    bh = h / r;
    tw = (tcol == c - 1) ? w - bw * (c - 1) : bw;
    th = (trow == r - 1) ? h - bh * (r - 1) : bh;
    data = tw * b;
    rb = (data + 3) & ~64'd3;
  endfunction

  function automatic tile_map_t map_position(input tile_req_t q);
    tile_map_t m;
    longint unsigned tw, th, data, rb, w, b, c, bw, bh, stride, trow, tcol, orow, obyte;
    m = '0;
    if (!setup_valid() || q.trow >= grid_r || q.tcol >= grid_c) begin
      m.status = StatusInvalid;
      return m;
    end
    tile_dims(q.trow, q.tcol, tw, th, data, rb);
    w = img_w;
    b = pix_bytes;
    c = grid_c;
    bw = w / c;
    bh = longint'(img_h) / longint'(grid_r);
    stride = (w * b + 3) & ~64'd3;
    trow = q.trow;
    tcol = q.tcol;
    orow = q.orow;
    obyte = q.obyte;
    m.tile_width = 13'(tw);
    m.tile_height = 13'(th);
    m.tile_row_bytes = 15'(rb);
    m.tile_pixels = 25'(tw * th);
    m.tile_number = 13'(trow * c + tcol + 1);
    m.status = StatusOk;
    if (orow >= th || obyte >= rb) begin
      m.status = StatusOutside;
    end else if (obyte >= data) begin
      m.is_pad = 1'b1;
    end else begin
      m.src_offset = 26'((orow + trow * bh) * stride + tcol * bw * b + obyte);
    end
    return m;
  endfunction

  function automatic tile_req_t make_request();
    tile_req_t q;
    longint unsigned tw, th, data, rb;
    int pick;
    q.trow = 6'($urandom);
    q.tcol = 6'($urandom);
    q.orow = 12'($urandom);
    q.obyte = 14'($urandom);
    pick = $urandom_range(99);
    if (!setup_valid() || pick >= 88) return q;
    q.trow = 6'($urandom_range(32'(grid_r - 7'd1)));
    q.tcol = 6'($urandom_range(32'(grid_c - 7'd1)));
    tile_dims(q.trow, q.tcol, tw, th, data, rb);
    q.orow = 12'($urandom_range(32'(th - 1)));
    q.obyte = 14'($urandom_range(32'(rb - 1)));
    if (pick < 15 && rb > data) begin
      q.obyte = 14'($urandom_range(32'(rb - 1), 32'(data)));
    end else if (pick < 22) begin
      q.orow = 12'(th - 1);
      q.obyte = 14'(data - 1);
    end else if (pick < 26) begin
      q.obyte = 14'(rb);
    end else if (pick < 30) begin
      q.orow = 12'(th);
    end else if (pick < 33) begin
      q.trow = 6'(grid_r);
    end else if (pick < 36) begin
      q.tcol = 6'(grid_c);
    end else if (pick < 40) begin
      q.orow = '0;
      q.obyte = '0;
    end
    return q;
  endfunction

  task automatic add_req(input int trow, input int tcol, input int orow, input int obyte);
    tile_req_t q;
    q.trow = 6'(trow);
    q.tcol = 6'(tcol);
    q.orow = 12'(orow);
    q.obyte = 14'(obyte);
    tile_reqs.push_back(q);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgImageWidth:  img_w = val;
      CfgImageHeight: img_h = val;
      CfgBytesPerPix: pix_bytes = val[2:0];
      CfgGridRows:    grid_r = val[6:0];
      CfgGridCols:    grid_c = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, input int h, input int b, input int r, input int c);
    write_reg(CfgImageWidth, CfgDataW'(w));
    write_reg(CfgImageHeight, CfgDataW'(h));
    write_reg(CfgBytesPerPix, CfgDataW'(b));
    write_reg(CfgGridRows, CfgDataW'(r));
    write_reg(CfgGridCols, CfgDataW'(c));
    @(negedge clk_i);
  endtask

  task automatic random_config();
    int w, h, b, r, c, mode;
    mode = $urandom_range(99);
    w = (mode < 35) ? $urandom_range(MaxDim, 1) : $urandom_range(64, 1);
    h = ($urandom_range(99) < 35) ? $urandom_range(MaxDim, 1) : $urandom_range(64, 1);
    if (mode < 6) begin
      w = MaxDim;
      h = MaxDim;
    end else if (mode < 10) begin
      w = 1;
      h = 1;
    end
    b = $urandom_range(MaxBpp, 1);
    r = $urandom_range((h > MaxGrid) ? MaxGrid : h, 1);
    c = $urandom_range((w > MaxGrid) ? MaxGrid : w, 1);
    if ($urandom_range(3) == 0) r = (h > MaxGrid) ? MaxGrid : h;
    if ($urandom_range(3) == 0) c = (w > MaxGrid) ? MaxGrid : w;
    // upper bits beyond the register width are dropped
    if ($urandom_range(1) == 0) begin
      b = b | ($urandom_range(1023) << 3);
      r = r | ($urandom_range(63) << 7);
      c = c | ($urandom_range(63) << 7);
    end
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: w = ($urandom_range(1) == 0) ? 0 : $urandom_range(8191, MaxDim + 1);
        1: h = ($urandom_range(1) == 0) ? 0 : $urandom_range(8191, MaxDim + 1);
        2: b = ($urandom_range(1) == 0) ? 0 : $urandom_range(7, MaxBpp + 1);
        3: r = ($urandom_range(1) == 0) ? 0 : $urandom_range(127, MaxGrid + 1);
        default: c = (w < MaxGrid) ? w + 1 : 0;
      endcase
    end
    set_config(w, h, b, r, c);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (tile_reqs.size() != 0 || start || expected_maps.size() != 0);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    tile_req_t q;
    if (rst_ni) begin
      if (start && !busy) begin
        q.trow = tile_row_i;
        q.tcol = tile_col_i;
        q.orow = out_row_i;
        q.obyte = out_byte_i;
        expected_maps.push_back(map_position(q));
      end
      if (!start || !busy) begin
        if (tile_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          q = tile_reqs.pop_front();
          start <= 1'b1;
          tile_row_i <= q.trow;
          tile_col_i <= q.tcol;
          out_row_i <= q.orow;
          out_byte_i <= q.obyte;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_maps.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
      end else begin
        map_head = expected_maps.pop_front();
        check_field("is_pad", map_head.is_pad, is_pad_o);
        check_field("src_offset", map_head.src_offset, src_offset_o);
        check_field("tile_width", map_head.tile_width, tile_width_o);
        check_field("tile_height", map_head.tile_height, tile_height_o);
        check_field("tile_row_bytes", map_head.tile_row_bytes, tile_row_bytes_o);
        check_field("tile_pixels", map_head.tile_pixels, tile_pixels_o);
        check_field("tile_number", map_head.tile_number, tile_number_o);
        check_field("status", map_head.status, status_o);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet < QuietLimit) begin
      quiet <= quiet + 1;
    end else begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setup: one pixel of three bytes, padded to four
    add_req(0, 0, 0, 0);
    add_req(0, 0, 0, 3);
    add_req(0, 0, 0, 4);
    add_req(0, 0, 1, 0);
    add_req(1, 0, 0, 0);
    add_req(0, 1, 0, 0);
    add_req(63, 63, 4095, 16383);
    drain();

    set_config(MaxDim, MaxDim, MaxBpp, 1, 1);
    add_req(0, 0, 4095, 16383);
    add_req(0, 0, 2048, 8191);
    drain();

    set_config(MaxDim, MaxDim, MaxBpp, MaxGrid, MaxGrid);
    add_req(63, 63, 63, 255);
    add_req(63, 63, 64, 0);
    add_req(0, 63, 0, 256);
    add_req(63, 0, 63, 255);
    drain();

    // remainder tiles in the last row and column
    set_config(100, 70, 3, 3, 7);
    add_req(0, 6, 0, 47);
    add_req(0, 5, 0, 42);
    add_req(2, 6, 23, 47);
    add_req(2, 6, 24, 0);
    add_req(1, 0, 22, 43);
    drain();

    set_config(100, 70, 0, 3, 7);
    add_req(0, 0, 0, 0);
    drain();
    set_config(10, 5, 3, 6, 2);
    add_req(0, 0, 0, 0);
    drain();
    set_config(0, 5, 3, 1, 1);
    add_req(0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      random_config();
      idle_pct = pct_list[ph % 3];
      repeat (110) tile_reqs.push_back(make_request());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
